>>> hw/rtl/ps2a_pkg.sv
// Shared types, codes and key tables for the scancode set 1 to ASCII translator.
`default_nettype none

package ps2a_pkg;

    localparam int unsigned SCAN_W  = 8;
    localparam int unsigned CHAR_W  = 7;
    localparam int unsigned CODE_W  = 7;
    localparam int unsigned INDEX_W = 6;

    localparam logic [SCAN_W-1:0] PREFIX_BYTE = 8'hE0;
    localparam int unsigned       BREAK_BIT   = 7;
    localparam logic [CODE_W-1:0] LSHIFT_CODE = 7'h2A;
    localparam logic [CODE_W-1:0] RSHIFT_CODE = 7'h36;
    localparam logic [CODE_W-1:0] LCTRL_CODE  = 7'h1D;
    localparam logic [CODE_W-1:0] KEY_COUNT   = 7'd58;

    localparam logic [CHAR_W-1:0] CHAR_NONE    = 7'h00;
    localparam logic [CHAR_W-1:0] CHAR_LOWER_A = 7'h61;
    localparam logic [CHAR_W-1:0] CHAR_LOWER_Z = 7'h7A;
    localparam logic [CHAR_W-1:0] CHAR_UPPER_A = 7'h41;
    localparam logic [CHAR_W-1:0] CHAR_UPPER_Z = 7'h5A;
    localparam logic [CHAR_W-1:0] CTRL_LAST    = 7'h1A;

    typedef struct packed {
        logic shift;
        logic ctrl;
        logic ext;
    } ps2a_flags_t;

    typedef struct packed {
        logic              valid;
        logic [CHAR_W-1:0] ch;
    } ps2a_result_t;

    function automatic logic [CHAR_W-1:0] plain_char(input logic [INDEX_W-1:0] code);
        logic [CHAR_W-1:0] c;
        case (code)
            6'd1:  c = 7'd27;  6'd2:  c = 7'h31; 6'd3:  c = 7'h32; 6'd4:  c = 7'h33;
            6'd5:  c = 7'h34;  6'd6:  c = 7'h35; 6'd7:  c = 7'h36; 6'd8:  c = 7'h37;
            6'd9:  c = 7'h38;  6'd10: c = 7'h39; 6'd11: c = 7'h30; 6'd12: c = 7'h2D;
            6'd13: c = 7'h3D;  6'd14: c = 7'd8;  6'd15: c = 7'd9;  6'd16: c = 7'h71;
            6'd17: c = 7'h77;  6'd18: c = 7'h65; 6'd19: c = 7'h72; 6'd20: c = 7'h74;
            6'd21: c = 7'h79;  6'd22: c = 7'h75; 6'd23: c = 7'h69; 6'd24: c = 7'h6F;
            6'd25: c = 7'h70;  6'd26: c = 7'h5B; 6'd27: c = 7'h5D; 6'd28: c = 7'd10;
            6'd30: c = 7'h61;  6'd31: c = 7'h73; 6'd32: c = 7'h64; 6'd33: c = 7'h66;
            6'd34: c = 7'h67;  6'd35: c = 7'h68; 6'd36: c = 7'h6A; 6'd37: c = 7'h6B;
            6'd38: c = 7'h6C;  6'd39: c = 7'h3B; 6'd40: c = 7'd39; 6'd41: c = 7'h60;
            6'd43: c = 7'd92;  6'd44: c = 7'h7A; 6'd45: c = 7'h78; 6'd46: c = 7'h63;
            6'd47: c = 7'h76;  6'd48: c = 7'h62; 6'd49: c = 7'h6E; 6'd50: c = 7'h6D;
            6'd51: c = 7'h2C;  6'd52: c = 7'h2E; 6'd53: c = 7'h2F; 6'd55: c = 7'h2A;
            6'd57: c = 7'h20;
            default: c = CHAR_NONE;
        endcase
        return c;
    endfunction

    function automatic logic [CHAR_W-1:0] shifted_char(input logic [INDEX_W-1:0] code);
        logic [CHAR_W-1:0] c;
        case (code)
            6'd1:  c = 7'd27;  6'd2:  c = 7'h21; 6'd3:  c = 7'h40; 6'd4:  c = 7'h23;
            6'd5:  c = 7'h24;  6'd6:  c = 7'h25; 6'd7:  c = 7'h5E; 6'd8:  c = 7'h26;
            6'd9:  c = 7'h2A;  6'd10: c = 7'h28; 6'd11: c = 7'h29; 6'd12: c = 7'h5F;
            6'd13: c = 7'h2B;  6'd14: c = 7'd8;  6'd15: c = 7'd9;  6'd16: c = 7'h51;
            6'd17: c = 7'h57;  6'd18: c = 7'h45; 6'd19: c = 7'h52; 6'd20: c = 7'h54;
            6'd21: c = 7'h59;  6'd22: c = 7'h55; 6'd23: c = 7'h49; 6'd24: c = 7'h4F;
            6'd25: c = 7'h50;  6'd26: c = 7'h7B; 6'd27: c = 7'h7D; 6'd28: c = 7'd10;
            6'd30: c = 7'h41;  6'd31: c = 7'h53; 6'd32: c = 7'h44; 6'd33: c = 7'h46;
            6'd34: c = 7'h47;  6'd35: c = 7'h48; 6'd36: c = 7'h4A; 6'd37: c = 7'h4B;
            6'd38: c = 7'h4C;  6'd39: c = 7'h3A; 6'd40: c = 7'd34; 6'd41: c = 7'h7E;
            6'd43: c = 7'h7C;  6'd44: c = 7'h5A; 6'd45: c = 7'h58; 6'd46: c = 7'h43;
            6'd47: c = 7'h56;  6'd48: c = 7'h42; 6'd49: c = 7'h4E; 6'd50: c = 7'h4D;
            6'd51: c = 7'h3C;  6'd52: c = 7'h3E; 6'd53: c = 7'h3F; 6'd55: c = 7'h2A;
            6'd57: c = 7'h20;
            default: c = CHAR_NONE;
        endcase
        return c;
    endfunction

endpackage

`default_nettype wire

>>> hw/rtl/ps2a_decode.sv
// Combinational decode of one scancode byte against the modifier flags.
`default_nettype none

module ps2a_decode (
    input  wire logic [ps2a_pkg::SCAN_W-1:0] scan_byte,
    input  wire ps2a_pkg::ps2a_flags_t       flags,
    output ps2a_pkg::ps2a_flags_t            flags_next,
    output ps2a_pkg::ps2a_result_t           result
);
    import ps2a_pkg::*;

    logic              released;
    logic [CODE_W-1:0] code;
    logic [CHAR_W-1:0] ch;

    assign released = scan_byte[BREAK_BIT];
    assign code     = scan_byte[CODE_W-1:0];
    assign ch       = flags.shift ? shifted_char(code[INDEX_W-1:0])
                                  : plain_char(code[INDEX_W-1:0]);

    always_comb begin
        flags_next   = flags;
        result.valid = 1'b0;
        result.ch    = ch;
        if (scan_byte == PREFIX_BYTE) begin
            flags_next.ext = 1'b1;
        end else if (flags.ext) begin
            flags_next.ext = 1'b0;
        end else if (code == LSHIFT_CODE || code == RSHIFT_CODE) begin
            flags_next.shift = ~released;
        end else if (code == LCTRL_CODE) begin
            flags_next.ctrl = ~released;
        end else if (!released && code < KEY_COUNT && ch != CHAR_NONE) begin
            if (!flags.ctrl) begin
                result.valid = 1'b1;
            end else if (ch inside {[CHAR_LOWER_A:CHAR_LOWER_Z]}) begin
                result.valid = 1'b1;
                result.ch    = ch - (CHAR_LOWER_A - 7'd1);
            end else if (ch inside {[CHAR_UPPER_A:CHAR_UPPER_Z]}) begin
                result.valid = 1'b1;
                result.ch    = ch - (CHAR_UPPER_A - 7'd1);
            end
        end
    end

endmodule

`default_nettype wire

>>> hw/rtl/ps2_scancode_to_ascii.sv
// Top level: input register, modifier flags and result register of the translator.
//
//  channel | ports         | tdata (low bit up)              | per word
//  --------+---------------+---------------------------------+---------------------
//  input   | s_axis_*      | [7:0] scan_byte                 | one scancode byte
//  result  | m_axis_*      | [6:0] ascii_char, [7] zero      | zero or one per byte
//
// One word per cycle while the result register is free or drains: a byte is
// held in the input register, is decoded against the flags and lands in the
// result register as it advances. Reset clears the flags and both valid bits.
// A stalled result holds; the input register takes a word while it is empty
// or while the result register is free or drains.
`default_nettype none

module ps2_scancode_to_ascii (
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       s_axis_tvalid,
    output logic            s_axis_tready,
    input  wire logic [7:0] s_axis_tdata,   // [7:0] scan_byte
    output logic            m_axis_tvalid,
    input  wire logic       m_axis_tready,
    output logic [7:0]      m_axis_tdata    // [6:0] ascii_char, [7] zero
);
    import ps2a_pkg::*;

    logic              in_valid_reg;
    logic [SCAN_W-1:0] byte_reg;
    ps2a_flags_t       flags_reg;
    ps2a_flags_t       flags_next;
    ps2a_result_t      dec_result;
    logic              out_valid_reg;
    logic [CHAR_W-1:0] char_reg;
    logic              advance;

    assign advance       = in_valid_reg && (!out_valid_reg || m_axis_tready);
    assign s_axis_tready = !in_valid_reg || advance;

    ps2a_decode u_decode (
        .scan_byte  (byte_reg),
        .flags      (flags_reg),
        .flags_next (flags_next),
        .result     (dec_result)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            flags_reg     <= '0;
        end else begin
            if (s_axis_tready) begin
                in_valid_reg <= s_axis_tvalid;
            end
            if (advance) begin
                flags_reg     <= flags_next;
                out_valid_reg <= dec_result.valid;
            end else if (m_axis_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_axis_tready && s_axis_tvalid) begin
            byte_reg <= s_axis_tdata;
        end
        if (advance && dec_result.valid) begin
            char_reg <= dec_result.ch;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {1'b0, char_reg};

`ifndef SYNTHESIS
    a_prefix_arms: assert property (@(posedge aclk) disable iff (!aresetn)
        advance && byte_reg == PREFIX_BYTE |=> flags_reg.ext && !m_axis_tvalid)
        else $error("prefix byte did not arm the extended flag");

    a_prefix_swallows: assert property (@(posedge aclk) disable iff (!aresetn)
        advance && flags_reg.ext && byte_reg != PREFIX_BYTE |=> !flags_reg.ext && !m_axis_tvalid)
        else $error("byte after prefix was not swallowed");

    a_ctrl_letter: assert property (@(posedge aclk) disable iff (!aresetn)
        advance && flags_reg.ctrl && dec_result.valid
        |=> m_axis_tdata != 8'd0 && m_axis_tdata <= {1'b0, CTRL_LAST})
        else $error("ctrl result outside control letter range");

    a_no_stall_loss: assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg && !m_axis_tready |=> out_valid_reg && $stable(char_reg))
        else $error("stalled result lost by the result register");
`endif

endmodule

`default_nettype wire
